// ----- rtl/cgbs_pkg.sv -----
// ----------------------------------------------------------------------------
// cgbs_pkg
// Shared constants for the cost grid bilinear sampler: fixed point format,
// action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cgbs_pkg;

    localparam int FRAC = 16;
    localparam int DEFAULT_MAX_GRID_WIDTH  = 256;
    localparam int DEFAULT_MAX_GRID_HEIGHT = 256;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_CHECKED = 2'd1;
    localparam logic [1:0] ACT_CLAMPED = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CPM         = 3'd4;

    localparam logic [8:0]  RESET_GRID_SIZE = 9'd256;
    localparam logic [23:0] RESET_CPM       = 24'd1310720;

    localparam int BANKS = 4;

endpackage

`default_nettype wire

// ----- rtl/cgbs_ram.sv -----
// ----------------------------------------------------------------------------
// cgbs_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cgbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]      wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/cost_grid_bilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// cost_grid_bilinear_sampler
// Bilinear sampling of an 8-bit cost grid with map-space gradient.
// ----------------------------------------------------------------------------
// a sample result is strobed on done after the offset, scale, clamp, bank read, product and sum stages
// throughput: one transaction per cycle, busy is always low; the four neighbours
// come from four parity-interleaved RAM banks read in the same cycle
// results cannot be stalled by the receiver; writes land in the bank stage so
// they stay ordered with samples
// reset clears config registers to defaults and all valid bits; cost store is
// undefined until written
`default_nettype none

module cost_grid_bilinear_sampler #(
    parameter int MAX_GRID_WIDTH  = cgbs_pkg::DEFAULT_MAX_GRID_WIDTH,
    parameter int MAX_GRID_HEIGHT = cgbs_pkg::DEFAULT_MAX_GRID_HEIGHT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire [1:0]            action,
    input  wire [7:0]            cell_x,
    input  wire [7:0]            cell_y,
    input  wire [7:0]            cost,
    input  wire signed [31:0]    query_x,
    input  wire signed [31:0]    query_y,
    input  wire                  cfg_we,
    input  wire [cgbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [cgbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                 done,
    output logic                 inside_res,
    output logic [23:0]          value,
    output logic signed [32:0]   grad_x,
    output logic signed [32:0]   grad_y
);

    localparam int F    = cgbs_pkg::FRAC;
    localparam int XW   = $clog2(MAX_GRID_WIDTH);
    localparam int YW   = $clog2(MAX_GRID_HEIGHT);
    localparam int NXW  = $clog2(MAX_GRID_WIDTH + 1);
    localparam int NYW  = $clog2(MAX_GRID_HEIGHT + 1);
    localparam int XH   = (MAX_GRID_WIDTH + 1) / 2;
    localparam int YH   = (MAX_GRID_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = XH * YH;
    localparam int AW   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PW   = 58;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    assign busy = 1'b0;

    // configuration registers
    logic [8:0]         grid_width_reg, grid_height_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [23:0]        cpm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= cgbs_pkg::RESET_GRID_SIZE;
            grid_height_reg <= cgbs_pkg::RESET_GRID_SIZE;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cpm_reg         <= cgbs_pkg::RESET_CPM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cgbs_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[8:0];
                cgbs_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[8:0];
                cgbs_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                cgbs_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                cgbs_pkg::REG_CPM:         cpm_reg         <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // effective grid sizes, zero acts as one and oversize saturates
    logic [NXW-1:0] nx;
    logic [NYW-1:0] ny;
    always_comb
    begin
        if (grid_width_reg == 9'd0)
            nx = NXW'(1);
        else if (32'(grid_width_reg) > MAX_GRID_WIDTH)
            nx = NXW'(MAX_GRID_WIDTH);
        else
            nx = NXW'(grid_width_reg);
        if (grid_height_reg == 9'd0)
            ny = NYW'(1);
        else if (32'(grid_height_reg) > MAX_GRID_HEIGHT)
            ny = NYW'(MAX_GRID_HEIGHT);
        else
            ny = NYW'(grid_height_reg);
    end

    // ---------------- stage 1: offsets from origin
    logic               v1_reg;
    logic [1:0]         act1_reg;
    logic [7:0]         cx1_reg, cy1_reg, cost1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic               v1_next;

    assign v1_next = start && !busy && (action != cgbs_pkg::ACT_UNUSED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v1_next;
    end

    always_ff @(posedge clk)
    begin
        act1_reg  <= action;
        cx1_reg   <= cell_x;
        cy1_reg   <= cell_y;
        cost1_reg <= cost;
        dx1_reg   <= 33'(query_x) - 33'(origin_x_reg);
        dy1_reg   <= 33'(query_y) - 33'(origin_y_reg);
    end

    // ---------------- stage 2: scale to cells
    logic                 v2_reg;
    logic [1:0]           act2_reg;
    logic [7:0]           cx2_reg, cy2_reg, cost2_reg;
    logic signed [PW-1:0] px2_reg, py2_reg;
    logic signed [24:0]   cpm_s;

    assign cpm_s = $signed({1'b0, cpm_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        act2_reg  <= act1_reg;
        cx2_reg   <= cx1_reg;
        cy2_reg   <= cy1_reg;
        cost2_reg <= cost1_reg;
        px2_reg   <= dx1_reg * cpm_s;
        py2_reg   <= dy1_reg * cpm_s;
    end

    // ---------------- stage 3: centre, clamp and footprint check
    logic                 v3_reg;
    logic [1:0]           act3_reg;
    logic [7:0]           cx3_reg, cy3_reg, cost3_reg;
    logic [XW+F-1:0]      gcx3_reg;
    logic [YW+F-1:0]      gcy3_reg;
    logic                 clx3_reg, cly3_reg, out3_reg;

    logic signed [PW-1:0] gx, gy, maxqx, maxqy, limx, limy;
    logic [XW+F-1:0]      gcx_next;
    logic [YW+F-1:0]      gcy_next;
    logic                 clx_next, cly_next, out_next;

    always_comb
    begin
        gx    = (px2_reg >>> F) - PW'(1 << (F - 1));
        gy    = (py2_reg >>> F) - PW'(1 << (F - 1));
        maxqx = PW'(nx - NXW'(1)) << F;
        maxqy = PW'(ny - NYW'(1)) << F;
        limx  = PW'(nx) << (2 * F);
        limy  = PW'(ny) << (2 * F);
        clx_next = (gx < 0) || (gx > maxqx);
        cly_next = (gy < 0) || (gy > maxqy);
        if (gx < 0)
            gcx_next = '0;
        else if (gx > maxqx)
            gcx_next = maxqx[XW+F-1:0];
        else
            gcx_next = gx[XW+F-1:0];
        if (gy < 0)
            gcy_next = '0;
        else if (gy > maxqy)
            gcy_next = maxqy[YW+F-1:0];
        else
            gcy_next = gy[YW+F-1:0];
        out_next = (act2_reg == cgbs_pkg::ACT_CHECKED) &&
                   ((px2_reg < 0) || (py2_reg < 0) || (px2_reg >= limx) ||
                    (py2_reg >= limy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        act3_reg  <= act2_reg;
        cx3_reg   <= cx2_reg;
        cy3_reg   <= cy2_reg;
        cost3_reg <= cost2_reg;
        gcx3_reg  <= gcx_next;
        gcy3_reg  <= gcy_next;
        clx3_reg  <= clx_next;
        cly3_reg  <= cly_next;
        out3_reg  <= out_next;
    end

    // ---------------- stage 4: bank read and weights
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [F-1:0]  tx, ty;
    logic [F:0]    wx0, wy0, wx1, wy1;

    always_comb
    begin
        x0  = gcx3_reg[F +: XW];
        y0  = gcy3_reg[F +: YW];
        tx  = gcx3_reg[F-1:0];
        ty  = gcy3_reg[F-1:0];
        x1  = (32'(x0) == 32'(nx) - 1) ? x0 : x0 + XW'(1);
        y1  = (32'(y0) == 32'(ny) - 1) ? y0 : y0 + YW'(1);
        wx0 = ONE - (F+1)'(tx);
        wy0 = ONE - (F+1)'(ty);
        wx1 = (F+1)'(tx);
        wy1 = (F+1)'(ty);
    end

    logic wr_ok;
    logic [AW-1:0] waddr;
    assign wr_ok = v3_reg && (act3_reg == cgbs_pkg::ACT_WRITE) &&
                   (32'(cx3_reg) < MAX_GRID_WIDTH) && (32'(cy3_reg) < MAX_GRID_HEIGHT);
    assign waddr = AW'(32'(cy3_reg >> 1) * XH + 32'(cx3_reg >> 1));

    logic [7:0] bank_data [cgbs_pkg::BANKS];

    for (genvar b = 0; b < cgbs_pkg::BANKS; b++)
    begin : g_bank
        logic [XW-1:0] col;
        logic [YW-1:0] row;
        logic [AW-1:0] raddr;
        logic          we;
        assign col   = (x0[0] == b[0]) ? x0 : x1;
        assign row   = (y0[0] == b[1]) ? y0 : y1;
        assign raddr = AW'(32'(row >> 1) * XH + 32'(col >> 1));
        assign we    = wr_ok && ({cy3_reg[0], cx3_reg[0]} == 2'(b));
        cgbs_ram #(
            .WIDTH(8),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (we),
            .waddr(waddr),
            .wdata(cost3_reg),
            .raddr(raddr),
            .rdata(bank_data[b])
        );
    end

    logic        v4_reg;
    logic [1:0]  act4_reg;
    logic        clx4_reg, cly4_reg, out4_reg;
    logic [1:0]  sel00_reg, sel10_reg, sel01_reg, sel11_reg;
    logic [F:0]  w00_reg, w10_reg, w01_reg, w11_reg;
    logic [23:0] gwy0_reg, gwy1_reg, gwx0_reg, gwx1_reg;
    logic [2*F+1:0] w00_p, w10_p, w01_p, w11_p;
    logic [F+24:0]  gwy0_p, gwy1_p, gwx0_p, gwx1_p;

    always_comb
    begin
        w00_p  = wx0 * wy0;
        w10_p  = wx1 * wy0;
        w01_p  = wx0 * wy1;
        w11_p  = wx1 * wy1;
        gwy0_p = wy0 * cpm_reg;
        gwy1_p = wy1 * cpm_reg;
        gwx0_p = wx0 * cpm_reg;
        gwx1_p = wx1 * cpm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        act4_reg  <= act3_reg;
        clx4_reg  <= clx3_reg;
        cly4_reg  <= cly3_reg;
        out4_reg  <= out3_reg;
        sel00_reg <= {y0[0], x0[0]};
        sel10_reg <= {y0[0], x1[0]};
        sel01_reg <= {y1[0], x0[0]};
        sel11_reg <= {y1[0], x1[0]};
        w00_reg   <= w00_p[F +: F+1];
        w10_reg   <= w10_p[F +: F+1];
        w01_reg   <= w01_p[F +: F+1];
        w11_reg   <= w11_p[F +: F+1];
        gwy0_reg  <= gwy0_p[F +: 24];
        gwy1_reg  <= gwy1_p[F +: 24];
        gwx0_reg  <= gwx0_p[F +: 24];
        gwx1_reg  <= gwx1_p[F +: 24];
    end

    // ---------------- stage 5: products
    logic [7:0]        c00, c10, c01, c11;
    logic signed [8:0] d10_00, d11_01, d01_00, d11_10;

    always_comb
    begin
        c00 = bank_data[sel00_reg];
        c10 = bank_data[sel10_reg];
        c01 = bank_data[sel01_reg];
        c11 = bank_data[sel11_reg];
        d10_00 = $signed({1'b0, c10}) - $signed({1'b0, c00});
        d11_01 = $signed({1'b0, c11}) - $signed({1'b0, c01});
        d01_00 = $signed({1'b0, c01}) - $signed({1'b0, c00});
        d11_10 = $signed({1'b0, c11}) - $signed({1'b0, c10});
    end

    logic               v5_reg;
    logic [1:0]         act5_reg;
    logic               clx5_reg, cly5_reg, out5_reg;
    logic [F+8:0]       p00_reg, p10_reg, p01_reg, p11_reg;
    logic signed [33:0] gxa_reg, gxb_reg, gya_reg, gyb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        act5_reg <= act4_reg;
        clx5_reg <= clx4_reg;
        cly5_reg <= cly4_reg;
        out5_reg <= out4_reg;
        p00_reg  <= w00_reg * c00;
        p10_reg  <= w10_reg * c10;
        p01_reg  <= w01_reg * c01;
        p11_reg  <= w11_reg * c11;
        gxa_reg  <= $signed({1'b0, gwy0_reg}) * d10_00;
        gxb_reg  <= $signed({1'b0, gwy1_reg}) * d11_01;
        gya_reg  <= $signed({1'b0, gwx0_reg}) * d01_00;
        gyb_reg  <= $signed({1'b0, gwx1_reg}) * d11_10;
    end

    // ---------------- stage 6: sums and output register
    logic [F+10:0]      value_sum;
    logic signed [34:0] gx_sum, gy_sum;
    logic               done_next;

    always_comb
    begin
        value_sum = (F+11)'(p00_reg) + (F+11)'(p10_reg) + (F+11)'(p01_reg) +
                    (F+11)'(p11_reg);
        gx_sum    = 35'(gxa_reg) + 35'(gxb_reg);
        gy_sum    = 35'(gya_reg) + 35'(gyb_reg);
        done_next = v5_reg && (act5_reg != cgbs_pkg::ACT_WRITE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (out5_reg)
        begin
            inside_res <= 1'b0;
            value      <= '0;
            grad_x     <= '0;
            grad_y     <= '0;
        end
        else
        begin
            inside_res <= 1'b1;
            value      <= value_sum[23:0];
            grad_x     <= clx5_reg ? 33'sd0 : gx_sum[32:0];
            grad_y     <= cly5_reg ? 33'sd0 : gy_sum[32:0];
        end
    end

endmodule

`default_nettype wire
